/* hw/rtl/r5bmr_pkg.sv */
// Types and constants shared by the RAID-5 block map and rebuild unit.
`timescale 1ns / 1ps

package r5bmr_pkg;

  localparam int MAX_DRIVES = 16;

  localparam int BLOCK_W    = 32;
  localparam int DATA_W     = 64;
  localparam int DRV_W      = 4;
  localparam int COUNT_W    = 5;
  localparam int STRIPE_W   = 8;
  localparam int MASK_W     = 16;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [STRIPE_W-1:0] STRIPE_MASK = 8'b11111111;

  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_BLOCKS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_COUNT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_LAYOUT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC_LAYOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_MASK     = 3'd4;

  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_REPLY   = 1'b1;

  localparam logic [KIND_W-1:0] K_READ  = 2'd0;
  localparam logic [KIND_W-1:0] K_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] K_FAIL  = 2'd2;
  localparam logic [KIND_W-1:0] K_UNEXP = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV1 = 8'b0000_0010,
    S_DIV2 = 8'b0000_0100,
    S_DIV3 = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_MAP  = 8'b0010_0000,
    S_SCAN = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } seq_state_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_WAIT = 3'b010,
    PH_SCAN = 3'b100
  } phase_t;

  typedef struct packed {
    logic                go;
    logic [BLOCK_W-1:0]  dividend;
    logic [STRIPE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [BLOCK_W-1:0]  quotient;
    logic [STRIPE_W-1:0] remainder;
  } div_rsp_t;

endpackage

/* hw/rtl/r5bmr_item_if.sv */
// Handshake channel that carries one input item into the unit.
`timescale 1ns / 1ps

interface r5bmr_item_if import r5bmr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [BLOCK_W-1:0] logical_block;
  logic [DATA_W-1:0]  reply_data;
  logic               reply_ok;

  modport source (
    output valid, command, logical_block, reply_data, reply_ok,
    input  ready
  );

  modport sink (
    input  valid, command, logical_block, reply_data, reply_ok,
    output ready
  );
endinterface

/* hw/rtl/r5bmr_result_if.sv */
// Handshake channel that carries one result item out of the unit.
`timescale 1ns / 1ps

interface r5bmr_result_if import r5bmr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [DRV_W-1:0]   drive_index;
  logic [BLOCK_W-1:0] drive_block;
  logic [DATA_W-1:0]  data;

  modport source (
    output valid, kind, drive_index, drive_block, data,
    input  ready
  );

  modport sink (
    input  valid, kind, drive_index, drive_block, data,
    output ready
  );
endinterface

/* hw/rtl/r5bmr_div.sv */
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module r5bmr_div import r5bmr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(BLOCK_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(BLOCK_W - 1);

  logic                busy;
  logic                done;
  logic [STEP_W-1:0]   step;
  logic [BLOCK_W-1:0]  quo;
  logic [STRIPE_W-1:0] rem;
  logic [STRIPE_W-1:0] dvsr;

  logic [STRIPE_W:0]   trial;
  logic [STRIPE_W:0]   diff;
  logic                fits;
  logic [STRIPE_W-1:0] rem_next;

  assign trial    = {rem, quo[BLOCK_W-1]};
  assign fits     = trial >= {1'b0, dvsr};
  assign diff     = trial - {1'b0, dvsr};
  assign rem_next = fits ? diff[STRIPE_W-1:0] : trial[STRIPE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      quo  <= req.dividend;
      rem  <= '0;
      dvsr <= req.divisor;
    end else if (busy) begin
      quo <= {quo[BLOCK_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

/* hw/rtl/raid5_block_map_and_rebuild_unit.sv */
// Top level of the RAID-5 read controller with layout mapping and XOR rebuild.
`timescale 1ns / 1ps

// A read request takes its stripe, stripe row and parity rotation from three
// divisions on one shared bit-serial divider; each loads its operands, steps
// through the 32 quotient bits and hands on its result. A multiply and a
// mapping stage follow, then the output stage, or the rebuild scan if the
// data drive is absent. An unexpected item, a request with bad geometry, a
// good reply to the data drive read or a failed reply in a rebuild goes
// straight to the output stage. A reply that leads to the next read of a
// rebuild, or completes it, passes through the scan stage, stepping again
// past the data drive. The unit takes one item at a time and is ready again
// in the cycle its result is presented; a result that is not taken holds
// the unit in its output stage until the output register is free.
module raid5_block_map_and_rebuild_unit import r5bmr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  r5bmr_item_if.sink            item,
  r5bmr_result_if.source        result,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [STRIPE_W-1:0] unit_blocks;
  logic [COUNT_W-1:0]  drive_count;
  logic                left_layout;
  logic                symmetric_layout;
  logic [MASK_W-1:0]   present_mask;

  seq_state_t st, st_next;
  phase_t     phase, phase_next;

  logic [DRV_W-1:0]    target_drive;
  logic [COUNT_W-1:0]  scan_drive;
  logic [BLOCK_W-1:0]  physical_block;
  logic [DATA_W-1:0]   xor_accumulator;
  logic [STRIPE_W-1:0] block_offset;
  logic [BLOCK_W-1:0]  row;
  logic [DRV_W-1:0]    row_slot;
  logic [BLOCK_W-1:0]  row_base;

  logic                div_go;
  logic [BLOCK_W-1:0]  div_dividend;
  logic [STRIPE_W-1:0] div_divisor;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [KIND_W-1:0]   res_kind;
  logic [DRV_W-1:0]    res_drive;
  logic [BLOCK_W-1:0]  res_block;
  logic [DATA_W-1:0]   res_data;

  logic                out_valid;
  logic [KIND_W-1:0]   out_kind;
  logic [DRV_W-1:0]    out_drive;
  logic [BLOCK_W-1:0]  out_block;
  logic [DATA_W-1:0]   out_data;

  logic                emit;
  logic [KIND_W-1:0]   e_kind;
  logic [DRV_W-1:0]    e_drive;
  logic [BLOCK_W-1:0]  e_block;
  logic [DATA_W-1:0]   e_data;

  logic                accept;
  logic                geom_bad;
  logic                out_free;
  logic [DRV_W-1:0]    n_minus_one;
  logic [DRV_W-1:0]    rot;
  logic [DRV_W-1:0]    parity;
  logic [COUNT_W-1:0]  sym_sum;
  logic [COUNT_W-1:0]  sym_drive;
  logic [DRV_W-1:0]    asym_drive;
  logic [DRV_W-1:0]    drive_calc;
  logic [BLOCK_W+STRIPE_W-1:0] product;
  logic [BLOCK_W-1:0]  block_sum;
  logic                target_present;
  logic                scan_present;
  logic                scan_end;
  logic                scan_skip;

  function automatic logic drive_present(input logic [MASK_W-1:0] mask,
                                         input logic [COUNT_W-1:0] d);
    drive_present = (d < COUNT_W'(MASK_W)) && mask[d[DRV_W-1:0]];
  endfunction

  r5bmr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign div_req.go       = div_go;
  assign div_req.dividend = div_dividend;
  assign div_req.divisor  = div_divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_blocks      <= 8'd1;
      drive_count      <= 5'd3;
      left_layout      <= 1'b1;
      symmetric_layout <= 1'b1;
      present_mask     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_UNIT_BLOCKS:      unit_blocks      <= cfg_data[STRIPE_W-1:0] & STRIPE_MASK;
        CFG_DRIVE_COUNT:      drive_count      <= cfg_data[COUNT_W-1:0];
        CFG_LEFT_LAYOUT:      left_layout      <= cfg_data[0];
        CFG_SYMMETRIC_LAYOUT: symmetric_layout <= cfg_data[0];
        CFG_PRESENT_MASK:     present_mask     <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign item.ready = (st == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !out_valid || result.ready;

  assign geom_bad = (unit_blocks == '0) || (drive_count < 5'd2) ||
                    (drive_count > COUNT_W'(MAX_DRIVES));

  assign n_minus_one = DRV_W'(drive_count - 5'd1);
  assign rot         = div_rsp.remainder[DRV_W-1:0];
  assign parity      = left_layout ? (n_minus_one - rot) : rot;
  assign sym_sum     = {1'b0, parity} + 5'd1 + {1'b0, row_slot};
  assign sym_drive   = (sym_sum >= drive_count) ? (sym_sum - drive_count) : sym_sum;
  assign asym_drive  = row_slot + ((row_slot >= parity) ? 4'd1 : 4'd0);
  assign drive_calc  = symmetric_layout ? sym_drive[DRV_W-1:0] : asym_drive;

  assign product   = {{STRIPE_W{1'b0}}, row} * {{BLOCK_W{1'b0}}, unit_blocks};
  assign block_sum = row_base + {{(BLOCK_W-STRIPE_W){1'b0}}, block_offset};

  assign target_present = drive_present(present_mask, {1'b0, target_drive});
  assign scan_present   = drive_present(present_mask, scan_drive);
  assign scan_end       = scan_drive >= drive_count;
  assign scan_skip      = !scan_end && (scan_drive == {1'b0, target_drive});

  always_comb begin
    st_next    = st;
    phase_next = phase;
    emit       = 1'b0;
    e_kind     = K_UNEXP;
    e_drive    = '0;
    e_block    = '0;
    e_data     = '0;
    case (st)
      S_IDLE: begin
        if (item.valid) begin
          if (item.command == CMD_REQUEST) begin
            if (phase != PH_IDLE) begin
              emit = 1'b1;
            end else if (geom_bad) begin
              emit   = 1'b1;
              e_kind = K_FAIL;
            end else begin
              st_next = S_DIV1;
            end
          end else if (phase == PH_WAIT) begin
            if (item.reply_ok) begin
              emit       = 1'b1;
              e_kind     = K_DATA;
              e_data     = item.reply_data;
              phase_next = PH_IDLE;
            end else begin
              st_next = S_SCAN;
            end
          end else if (phase == PH_SCAN) begin
            if (!item.reply_ok) begin
              emit       = 1'b1;
              e_kind     = K_FAIL;
              phase_next = PH_IDLE;
            end else begin
              st_next = S_SCAN;
            end
          end else begin
            emit = 1'b1;
          end
        end
      end
      S_DIV1: if (div_rsp.done) st_next = S_DIV2;
      S_DIV2: if (div_rsp.done) st_next = S_DIV3;
      S_DIV3: if (div_rsp.done) st_next = S_MUL;
      S_MUL:  st_next = S_MAP;
      S_MAP: begin
        if (target_present) begin
          emit       = 1'b1;
          e_kind     = K_READ;
          e_drive    = target_drive;
          e_block    = block_sum;
          phase_next = PH_WAIT;
        end else begin
          st_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          emit       = 1'b1;
          e_kind     = K_DATA;
          e_data     = xor_accumulator;
          phase_next = PH_IDLE;
        end else if (!scan_skip) begin
          emit = 1'b1;
          if (scan_present) begin
            e_kind     = K_READ;
            e_drive    = scan_drive[DRV_W-1:0];
            e_block    = physical_block;
            phase_next = PH_SCAN;
          end else begin
            e_kind     = K_FAIL;
            phase_next = PH_IDLE;
          end
        end
      end
      S_EMIT: if (out_free) st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
    if (emit) begin
      st_next = S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= S_IDLE;
      phase  <= PH_IDLE;
      div_go <= 1'b0;
    end else begin
      st     <= st_next;
      phase  <= phase_next;
      div_go <= (st == S_IDLE && st_next == S_DIV1) ||
                ((st == S_DIV1 || st == S_DIV2) && div_rsp.done);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (item.command == CMD_REQUEST) begin
        div_dividend <= item.logical_block;
        div_divisor  <= unit_blocks;
      end else if (phase == PH_WAIT) begin
        xor_accumulator <= '0;
        scan_drive      <= '0;
      end else if (phase == PH_SCAN) begin
        xor_accumulator <= xor_accumulator ^ item.reply_data;
        scan_drive      <= scan_drive + 5'd1;
      end
    end
    if (st == S_DIV1 && div_rsp.done) begin
      block_offset <= div_rsp.remainder;
      div_dividend <= div_rsp.quotient;
      div_divisor  <= {{(STRIPE_W-COUNT_W){1'b0}}, drive_count - 5'd1};
    end
    if (st == S_DIV2 && div_rsp.done) begin
      row          <= div_rsp.quotient;
      row_slot     <= div_rsp.remainder[DRV_W-1:0];
      div_dividend <= div_rsp.quotient;
      div_divisor  <= {{(STRIPE_W-COUNT_W){1'b0}}, drive_count};
    end
    if (st == S_DIV3 && div_rsp.done) begin
      target_drive <= drive_calc;
    end
    if (st == S_MUL) begin
      row_base <= product[BLOCK_W-1:0];
    end
    if (st == S_MAP) begin
      physical_block <= block_sum;
      if (!target_present) begin
        xor_accumulator <= '0;
        scan_drive      <= '0;
      end
    end
    if (st == S_SCAN && scan_skip) begin
      scan_drive <= scan_drive + 5'd1;
    end
    if (emit) begin
      res_kind  <= e_kind;
      res_drive <= e_drive;
      res_block <= e_block;
      res_data  <= e_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_EMIT && out_free) begin
      out_kind  <= res_kind;
      out_drive <= res_drive;
      out_block <= res_block;
      out_data  <= res_data;
    end
  end

  assign result.valid       = out_valid;
  assign result.kind        = out_kind;
  assign result.drive_index = out_drive;
  assign result.drive_block = out_block;
  assign result.data        = out_data;

endmodule

/* tb/sv/raid5_block_map_and_rebuild_unit_tb.sv */
// Self-checking testbench for the RAID-5 block map and rebuild unit.
`timescale 1ns / 1ps

module raid5_block_map_and_rebuild_unit_tb;
  import r5bmr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int PRINT_LIMIT    = 40;
  localparam int RANDOM_ITEMS   = 624;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DRV_W-1:0]   drive_index;
    logic [BLOCK_W-1:0] drive_block;
    logic [DATA_W-1:0]  data;
  } read_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  r5bmr_item_if   item_ch ();
  r5bmr_result_if result_ch ();

  raid5_block_map_and_rebuild_unit dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [STRIPE_W-1:0] cfg_stripe;
  logic [COUNT_W-1:0]  cfg_drives;
  logic                cfg_left;
  logic                cfg_sym;
  logic [MASK_W-1:0]   cfg_mask;

  phase_t              rb_phase;
  logic [DRV_W-1:0]    data_drive;
  logic [DRV_W-1:0]    scan_pos;
  logic [BLOCK_W-1:0]  data_block;
  logic [DATA_W-1:0]   parity_acc;

  read_result_t pending_results[$];

  int send_gap_pct;
  int recv_stall_pct;
  int error_count;
  int stall_cycles;
  int requests_sent;
  int replies_sent;
  int kind_seen[4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic read_result_t make_result(logic [KIND_W-1:0] kind,
      logic [DRV_W-1:0] drv, logic [BLOCK_W-1:0] blk, logic [DATA_W-1:0] word);
    read_result_t r;
    r.kind        = kind;
    r.drive_index = drv;
    r.drive_block = blk;
    r.data        = word;
    return r;
  endfunction

  function automatic bit drive_attached(int d);
    return d < MASK_W && cfg_mask[d];
  endfunction

  // Looks for the next drive to read in a rebuild, never the data drive itself.
  function automatic read_result_t rebuild_from(int from);
    for (int d = from; d < int'(cfg_drives); d++) begin
      if (d == int'(data_drive)) continue;
      if (!drive_attached(d)) begin
        rb_phase = PH_IDLE;
        return make_result(K_FAIL, '0, '0, '0);
      end
      rb_phase = PH_SCAN;
      scan_pos = DRV_W'(d);
      return make_result(K_READ, DRV_W'(d), data_block, '0);
    end
    rb_phase = PH_IDLE;
    return make_result(K_DATA, '0, '0, parity_acc);
  endfunction

  function automatic read_result_t map_request(logic [BLOCK_W-1:0] blk);
    logic [31:0] n, s, stripe, row, slot, rot, parity, drv;
    n = 32'(cfg_drives);
    s = 32'(cfg_stripe);
    if (s == 0 || n < 2 || n > MAX_DRIVES) return make_result(K_FAIL, '0, '0, '0);
    stripe = blk / s;
    row    = stripe / (n - 1);
    slot   = stripe % (n - 1);
    rot    = row % n;
    parity = cfg_left ? n - 1 - rot : rot;
    drv    = cfg_sym ? (parity + 1 + slot) % n : slot + (slot >= parity ? 1 : 0);
    data_drive = drv[DRV_W-1:0];
    data_block = row * s + blk % s;
    if (drive_attached(int'(drv))) begin
      rb_phase = PH_WAIT;
      return make_result(K_READ, data_drive, data_block, '0);
    end
    parity_acc = '0;
    return rebuild_from(0);
  endfunction

  function automatic read_result_t predict_item(logic cmd, logic [BLOCK_W-1:0] blk,
      logic [DATA_W-1:0] word, logic ok);
    bit busy;
    busy = (rb_phase == PH_WAIT || rb_phase == PH_SCAN);
    if (cmd == CMD_REQUEST) begin
      if (busy) return make_result(K_UNEXP, '0, '0, '0);
      return map_request(blk);
    end
    if (!busy) return make_result(K_UNEXP, '0, '0, '0);
    if (rb_phase == PH_WAIT) begin
      if (ok) begin
        rb_phase = PH_IDLE;
        return make_result(K_DATA, '0, '0, word);
      end
      parity_acc = '0;
      return rebuild_from(0);
    end
    if (!ok) begin
      rb_phase = PH_IDLE;
      return make_result(K_FAIL, '0, '0, '0);
    end
    parity_acc ^= word;
    return rebuild_from(int'(scan_pos) + 1);
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic send_item(logic cmd, logic [BLOCK_W-1:0] blk, logic [DATA_W-1:0] word,
      logic ok);
    read_result_t expected;
    while ($urandom_range(99) < send_gap_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.command       <= cmd;
    item_ch.logical_block <= blk;
    item_ch.reply_data    <= word;
    item_ch.reply_ok      <= ok;
    do @(posedge clk); while (!item_ch.ready);
    expected = predict_item(cmd, blk, word, ok);
    pending_results.insert(pending_results.size(), expected);
    if (cmd == CMD_REQUEST) requests_sent++;
    else replies_sent++;
  endtask

  // Ends any open request with failed replies, then waits for every result.
  task automatic quiesce();
    while (rb_phase != PH_IDLE) send_item(CMD_REPLY, $urandom, {$urandom, $urandom}, 1'b0);
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    quiesce();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_UNIT_BLOCKS:      cfg_stripe = value[STRIPE_W-1:0];
      CFG_DRIVE_COUNT:      cfg_drives = value[COUNT_W-1:0];
      CFG_LEFT_LAYOUT:      cfg_left   = value[0];
      CFG_SYMMETRIC_LAYOUT: cfg_sym    = value[0];
      CFG_PRESENT_MASK:     cfg_mask   = value[MASK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic randomize_geometry();
    int n, s, pick, top;
    logic [MASK_W-1:0] mask;
    pick = $urandom_range(99);
    if (pick < 15) n = 2;
    else if (pick < 30) n = MAX_DRIVES;
    else if (pick < 33) n = $urandom_range(1) ? $urandom_range(1) : $urandom_range(31, 17);
    else n = $urandom_range(MAX_DRIVES, 3);
    pick = $urandom_range(99);
    if (pick < 10) s = 1;
    else if (pick < 20) s = 255;
    else if (pick < 22) s = 0;
    else s = $urandom_range(255, 1);
    top = (n >= 2 && n <= MAX_DRIVES) ? n - 1 : MASK_W - 1;
    pick = $urandom_range(99);
    mask = '1;
    if (pick >= 80) mask = MASK_W'($urandom_range(16'hFFFF));
    else if (pick >= 45) mask[$urandom_range(top)] = 1'b0;
    write_reg(CFG_UNIT_BLOCKS, s);
    write_reg(CFG_DRIVE_COUNT, n);
    write_reg(CFG_LEFT_LAYOUT, $urandom_range(1));
    write_reg(CFG_SYMMETRIC_LAYOUT, $urandom_range(1));
    write_reg(CFG_PRESENT_MASK, int'(mask));
  endtask

  // Reset geometry with no drive attached: the request fails, then a stray reply.
  task automatic test_reset_defaults();
    send_item(CMD_REQUEST, '0, '0, 1'b1);
    send_item(CMD_REPLY, '1, '1, 1'b1);
  endtask

  task automatic test_geometry_faults();
    write_reg(CFG_UNIT_BLOCKS, 0);
    send_item(CMD_REQUEST, '1, '0, 1'b0);
    write_reg(CFG_UNIT_BLOCKS, 1);
    write_reg(CFG_DRIVE_COUNT, 0);
    send_item(CMD_REQUEST, 32'h0000_0001, '0, 1'b0);
    write_reg(CFG_DRIVE_COUNT, 1);
    send_item(CMD_REQUEST, $urandom, '0, 1'b1);
    write_reg(CFG_DRIVE_COUNT, 31);
    send_item(CMD_REQUEST, $urandom, '0, 1'b1);
  endtask

  task automatic test_layout_variants();
    write_reg(CFG_UNIT_BLOCKS, 255);
    write_reg(CFG_DRIVE_COUNT, MAX_DRIVES);
    write_reg(CFG_PRESENT_MASK, 16'hFFFF);
    for (int i = 0; i < 4; i++) begin
      write_reg(CFG_LEFT_LAYOUT, (i >> 1) & 1);
      write_reg(CFG_SYMMETRIC_LAYOUT, i & 1);
      send_item(CMD_REQUEST, (i % 2 == 0) ? 32'hFFFF_FFFF : 32'h0, '0, 1'b0);
      if (i < 2) send_item(CMD_REPLY, '0, (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0, 1'b1);
    end
  endtask

  task automatic test_rebuild_paths();
    write_reg(CFG_UNIT_BLOCKS, 1);
    write_reg(CFG_DRIVE_COUNT, 4);
    write_reg(CFG_LEFT_LAYOUT, 0);
    write_reg(CFG_SYMMETRIC_LAYOUT, 0);
    write_reg(CFG_PRESENT_MASK, 16'h000F);
    send_item(CMD_REQUEST, 32'd5, '0, 1'b1);
    send_item(CMD_REPLY, '0, '1, 1'b0);
    send_item(CMD_REQUEST, 32'd7, '0, 1'b1);
    repeat (3) send_item(CMD_REPLY, '0, {$urandom, $urandom}, 1'b1);
    send_item(CMD_REQUEST, 32'd9, '0, 1'b1);
    send_item(CMD_REPLY, '0, '0, 1'b0);
    send_item(CMD_REPLY, '0, {$urandom, $urandom}, 1'b1);
    send_item(CMD_REPLY, '0, '0, 1'b0);
    // The data drive is missing; the rebuild must skip it rather than read it.
    write_reg(CFG_DRIVE_COUNT, 2);
    write_reg(CFG_LEFT_LAYOUT, 1);
    write_reg(CFG_SYMMETRIC_LAYOUT, 1);
    write_reg(CFG_PRESENT_MASK, 16'h0001);
    send_item(CMD_REQUEST, 32'd1, '0, 1'b1);
    send_item(CMD_REPLY, '0, {$urandom, $urandom}, 1'b1);
    // A second missing drive ends the rebuild with a failure.
    write_reg(CFG_DRIVE_COUNT, 3);
    send_item(CMD_REQUEST, 32'd1, '0, 1'b1);
    send_item(CMD_REPLY, '0, {$urandom, $urandom}, 1'b1);
  endtask

  task automatic test_random_traffic(int sender_gap, int receiver_stall, int item_total);
    int sent, until_reconfig;
    logic [BLOCK_W-1:0] blk;
    logic [DATA_W-1:0] word;
    send_gap_pct   = sender_gap;
    recv_stall_pct = receiver_stall;
    sent           = 0;
    until_reconfig = 0;
    while (sent < item_total) begin
      if (until_reconfig <= 0) begin
        randomize_geometry();
        until_reconfig = $urandom_range(90, 30);
      end
      blk  = $urandom_range(1) ? $urandom : $urandom_range(4095);
      word = {$urandom, $urandom};
      if (rb_phase == PH_IDLE) begin
        if ($urandom_range(99) < 8) send_item(CMD_REPLY, blk, word, 1'($urandom_range(1)));
        else send_item(CMD_REQUEST, blk, word, 1'($urandom_range(1)));
      end else if ($urandom_range(99) < 5) begin
        send_item(CMD_REQUEST, blk, word, 1'($urandom_range(1)));
      end else begin
        send_item(CMD_REPLY, blk, word,
                  $urandom_range(99) < ((rb_phase == PH_WAIT) ? 70 : 94));
      end
      sent++;
      until_reconfig--;
    end
  endtask

  always @(posedge clk) begin
    read_result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        kind_seen[result_ch.kind]++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result of kind %0d with none pending", result_ch.kind));
        end else begin
          want = pending_results.pop_front();
          if (result_ch.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", result_ch.kind, want.kind));
          if (result_ch.drive_index !== want.drive_index)
            report_mismatch($sformatf("drive_index %0d, expected %0d",
                                      result_ch.drive_index, want.drive_index));
          if (result_ch.drive_block !== want.drive_block)
            report_mismatch($sformatf("drive_block %h, expected %h",
                                      result_ch.drive_block, want.drive_block));
          if (result_ch.data !== want.data)
            report_mismatch($sformatf("data %h, expected %h", result_ch.data, want.data));
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("raid5_block_map_and_rebuild_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    rst                   <= 1'b1;
    cfg_wr_en             <= 1'b0;
    cfg_index             <= CFG_UNIT_BLOCKS;
    cfg_data              <= '0;
    item_ch.valid         <= 1'b0;
    item_ch.command       <= CMD_REQUEST;
    item_ch.logical_block <= '0;
    item_ch.reply_data    <= '0;
    item_ch.reply_ok      <= 1'b0;
    cfg_stripe     = 1;
    cfg_drives     = 3;
    cfg_left       = 1'b1;
    cfg_sym        = 1'b1;
    cfg_mask       = '0;
    rb_phase       = PH_IDLE;
    data_drive     = '0;
    scan_pos       = '0;
    data_block     = '0;
    parity_acc     = '0;
    send_gap_pct   = 33;
    recv_stall_pct = 54;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_geometry_faults();
    test_layout_variants();
    test_rebuild_paths();
    test_random_traffic(33, 54, RANDOM_ITEMS);
    test_random_traffic(54, 33, RANDOM_ITEMS);
    test_random_traffic(0, 0, RANDOM_ITEMS);

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d requests and %0d replies under three pacing modes.",
             requests_sent, replies_sent);
    $display("Results: %0d drive reads, %0d data words, %0d failures, %0d stray items.",
             kind_seen[K_READ], kind_seen[K_DATA], kind_seen[K_FAIL], kind_seen[K_UNEXP]);
    if (error_count == 0)
      $display("raid5_block_map_and_rebuild_unit_tb: clean");
    else
      $display("raid5_block_map_and_rebuild_unit_tb: errors");
    $finish;
  end

endmodule
